// ===== hw/rtl/att_pkg.sv =====
// Package for the allocation tracking table.
// Holds sizes, operation and status codes, and the controller/datapath structs.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package att_pkg;

   // Table geometry and field widths.
   localparam int TABLE_DEPTH  = 64;
   localparam int ADDRESS_BITS = 48;
   localparam int SIZE_BITS    = 32;
   localparam int OP_BITS      = 3;
   localparam int STATUS_BITS  = 2;
   localparam int COUNT_BITS   = $clog2(TABLE_DEPTH + 1);

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_BITS-1:0] OP_MODIFY = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_IGNORED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the accepted item
      logic match;  // register the per-slot compare results
      logic apply;  // commit the operation and load the result
   } att_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;  // result register holds an item that is not taken this cycle
   } att_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/att_if.sv =====
// Valid/ready channel interfaces for the allocation tracking table.
// One interface for request items and one for response items.
// Depends on att_pkg for field widths.
`default_nettype none

interface att_req_if;
   import att_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      operation;
   logic [ADDRESS_BITS-1:0] address;
   logic [SIZE_BITS-1:0]    size;
   logic [ADDRESS_BITS-1:0] replacement_address;

   modport source (output valid, operation, address, size, replacement_address, input ready);
   modport sink   (input valid, operation, address, size, replacement_address, output ready);
endinterface

interface att_rsp_if;
   import att_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [SIZE_BITS-1:0]   found_size;
   logic [COUNT_BITS-1:0]  live_count;

   modport source (output valid, status, found_size, live_count, input ready);
   modport sink   (input valid, status, found_size, live_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/att_ctrl.sv =====
// Controller for the allocation tracking table.
// Steps each item through capture, compare and commit; drives datapath commands.
// Depends on att_pkg.
`default_nettype none

module att_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output att_pkg::att_cmd_type       cmd,
   input  wire att_pkg::att_stat_type stat
);
   import att_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Commands follow directly from the state.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      cmd.load  = (state_ff == S_IDLE) && req_valid;
      cmd.match = (state_ff == S_MATCH);
      cmd.apply = (state_ff == S_APPLY) && !stat.out_busy;
   end

   // Next state: the commit waits until the result register can take a new item.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/att_datapath.sv =====
// Datapath for the allocation tracking table: slot registers, per-slot compare,
// shift network, live count and the result register.
// Depends on att_pkg; driven by att_ctrl commands.
`default_nettype none

module att_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire att_pkg::att_cmd_type              cmd,
   output att_pkg::att_stat_type                  stat,
   input  wire logic [att_pkg::OP_BITS-1:0]       req_operation,
   input  wire logic [att_pkg::ADDRESS_BITS-1:0]  req_address,
   input  wire logic [att_pkg::SIZE_BITS-1:0]     req_size,
   input  wire logic [att_pkg::ADDRESS_BITS-1:0]  req_replacement_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [att_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [att_pkg::SIZE_BITS-1:0]          rsp_found_size,
   output logic [att_pkg::COUNT_BITS-1:0]         rsp_live_count
);
   import att_pkg::*;

   localparam logic [TABLE_DEPTH-1:0] ONE_VEC = TABLE_DEPTH'(1);
   localparam logic [COUNT_BITS-1:0]  FULL_COUNT = COUNT_BITS'(TABLE_DEPTH);

   // Captured item.
   logic [OP_BITS-1:0]      op_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [SIZE_BITS-1:0]    size_ff;
   logic [ADDRESS_BITS-1:0] naddr_ff;

   // Slot storage, newest in slot 0; live slots are 0 to count-1.
   logic [ADDRESS_BITS-1:0] cell_addr_ff [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]    cell_size_ff [TABLE_DEPTH];
   logic [ADDRESS_BITS-1:0] prev_addr    [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]    prev_size    [TABLE_DEPTH];
   logic [ADDRESS_BITS-1:0] next_addr    [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]    next_size    [TABLE_DEPTH];
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;

   // Compare results and the derived hit vectors.
   logic [TABLE_DEPTH-1:0]  match_in;
   logic [TABLE_DEPTH-1:0]  match_ff;
   logic [TABLE_DEPTH-1:0]  hit_onehot;
   logic [TABLE_DEPTH-1:0]  at_or_after;
   logic                    hit;
   logic                    addr_nz;

   // Operation decode for the commit cycle.
   logic                    do_add;
   logic                    do_remove;
   logic                    do_modify;
   logic [STATUS_BITS-1:0]  status_in;
   logic [SIZE_BITS-1:0]    found_in;
   logic [SIZE_BITS-1:0]    hit_size;

   // Result register.
   logic                    rsp_valid_ff;
   logic [STATUS_BITS-1:0]  status_ff;
   logic [SIZE_BITS-1:0]    found_ff;
   logic [COUNT_BITS-1:0]   live_ff;

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign addr_nz       = (addr_ff != '0);

   // Capture the item when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         addr_ff  <= req_address;
         size_ff  <= req_size;
         naddr_ff <= req_replacement_address;
      end
   end

   // Neighbor wiring and per-slot compare.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_addr[g] = addr_ff;
         assign prev_size[g] = size_ff;
      end else begin : g_body
         assign prev_addr[g] = cell_addr_ff[g-1];
         assign prev_size[g] = cell_size_ff[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_tail
         assign next_addr[g] = cell_addr_ff[g];
         assign next_size[g] = cell_size_ff[g];
      end else begin : g_inner
         assign next_addr[g] = cell_addr_ff[g+1];
         assign next_size[g] = cell_size_ff[g+1];
      end

      assign match_in[g] = addr_nz && (COUNT_BITS'(g) < count_ff)
                           && (cell_addr_ff[g] == addr_ff);

      // Each slot takes its older or newer neighbor, or the new values in place.
      always_ff @(posedge clock) begin
         if (do_add) begin
            cell_addr_ff[g] <= prev_addr[g];
            cell_size_ff[g] <= prev_size[g];
         end else if (do_remove && at_or_after[g]) begin
            cell_addr_ff[g] <= next_addr[g];
            cell_size_ff[g] <= next_size[g];
         end else if (do_modify && hit_onehot[g]) begin
            cell_addr_ff[g] <= naddr_ff;
            cell_size_ff[g] <= size_ff;
         end
      end
   end

   // Register the compare vector.
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         match_ff <= match_in;
      end
   end

   // Newest match as a one-hot vector, and the slots from it onward.
   always_comb begin
      hit         = |match_ff;
      hit_onehot  = match_ff & (~match_ff + ONE_VEC);
      at_or_after = ~(hit_onehot - ONE_VEC);
   end

   // Size of the newest match.
   always_comb begin
      hit_size = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_size = hit_size | (cell_size_ff[i] & {SIZE_BITS{hit_onehot[i]}});
      end
   end

   // Decode the operation into updates, status and the new count.
   always_comb begin
      do_add    = 1'b0;
      do_remove = 1'b0;
      do_modify = 1'b0;
      status_in = ST_MISS;
      found_in  = '0;
      count_in  = count_ff;
      case (op_ff)
         OP_ADD: begin
            if (!addr_nz) begin
               status_in = ST_IGNORED;
            end else if (count_ff == FULL_COUNT) begin
               status_in = ST_FULL;
            end else begin
               do_add    = cmd.apply;
               status_in = ST_DONE;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               do_remove = cmd.apply;
               status_in = ST_DONE;
               count_in  = count_ff - COUNT_BITS'(1);
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               status_in = ST_DONE;
               found_in  = hit_size;
            end
         end
         OP_MODIFY: begin
            if (hit) begin
               do_modify = cmd.apply;
               status_in = ST_DONE;
            end
         end
         OP_CLEAR: begin
            status_in = ST_DONE;
            count_in  = '0;
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   // Live count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   // Result register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         live_ff   <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_size = found_ff;
   assign rsp_live_count = live_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/allocation_tracking_table.sv =====
// Top level of the allocation tracking table.
// Joins the controller and the datapath to the request and response channels.
// Depends on att_pkg, att_if, att_ctrl and att_datapath.
//
//   Channel   Direction  Handshake     Payload
//   req_ch    in         valid/ready   operation, address, size, replacement_address
//   rsp_ch    out        valid/ready   status, found_size, live_count
//
// After acceptance the compare state registers a compare in every slot, and the commit
// state commits the shift or rewrite; it waits while an earlier result is still held.
// One item is in flight at a time; the next is accepted in the cycle after the commit.
// Reset empties the table at once; slot contents are left as they were.
// A held result stalls only the commit of the following item, not its acceptance.
`default_nettype none

module allocation_tracking_table (
   input wire logic clock,
   input wire logic reset,
   att_req_if.sink  req_ch,
   att_rsp_if.source rsp_ch
);
   import att_pkg::*;

   att_cmd_type  cmd;
   att_stat_type stat;

   att_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   att_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_operation           (req_ch.operation),
      .req_address             (req_ch.address),
      .req_size                (req_ch.size),
      .req_replacement_address (req_ch.replacement_address),
      .rsp_valid               (rsp_ch.valid),
      .rsp_ready               (rsp_ch.ready),
      .rsp_status              (rsp_ch.status),
      .rsp_found_size          (rsp_ch.found_size),
      .rsp_live_count          (rsp_ch.live_count)
   );

endmodule

`default_nettype wire
